// ===== rtl/b64_pkg.sv =====
// Package for the base64 encoder: widths, padding constant, queue entry type
// and the sextet-to-character mapping. No dependencies.
`default_nettype none

package b64_pkg;

	localparam int BYTE_W  = 8;
	localparam int CHAR_W  = 7;
	localparam int GROUP_W = 24;

	localparam logic [CHAR_W-1:0] PAD_CHAR = 7'h3D;

	typedef struct packed {
		logic [GROUP_W-1:0] group;
		logic [1:0]         present;
		logic               last;
	} b64_group_t;

	function automatic logic [CHAR_W-1:0] sextet_char(input logic [5:0] v);
		logic [CHAR_W-1:0] w;
		w = {1'b0, v};
		if (v < 6'd26)
			return 7'd65 + w;
		else if (v < 6'd52)
			return 7'd71 + w;
		else if (v < 6'd62)
			return w - 7'd4;
		else if (v == 6'd62)
			return 7'd43;
		else
			return 7'd47;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/b64_if.sv =====
// Handshake channels of the base64 encoder: raw bytes in, characters out.
// Depends on b64_pkg.
`default_nettype none

interface b64_byte_if;
	import b64_pkg::*;
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] data_byte;
	logic              end_of_message;

	modport source(output valid, data_byte, end_of_message, input ready);
	modport sink(input valid, data_byte, end_of_message, output ready);
endinterface

interface b64_char_if;
	import b64_pkg::*;
	logic              valid;
	logic              ready;
	logic [CHAR_W-1:0] out_char;
	logic              out_last;

	modport source(output valid, out_char, out_last, input ready);
	modport sink(input valid, out_char, out_last, output ready);
endinterface

`default_nettype wire

// ===== rtl/base64_encoder.sv =====
// Base64 encoder: one byte per beat in, one character per beat out.
// Throughput: four characters per group at one a cycle while the sink is ready, set
// by the back end's single character output register.
// Reset: arst_n clears the pending count, queue pointers and output valid.
// Depends on b64_pkg, b64_if, b64_front, b64_queue, b64_back.
`default_nettype none

module base64_encoder #(
	parameter int QUEUE_DEPTH = 2
) (
	input wire logic clk,
	input wire logic arst_n,
	b64_byte_if.sink raw,
	b64_char_if.source enc
);
	import b64_pkg::*;

	b64_group_t push_entry;
	logic       push_valid;
	logic       push_ready;
	b64_group_t pop_entry;
	logic       pop_valid;
	logic       pop_ready;

	b64_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.raw        (raw),
		.push_entry (push_entry),
		.push_valid (push_valid),
		.push_ready (push_ready)
	);

	b64_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_entry (push_entry),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.pop_entry  (pop_entry),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready)
	);

	b64_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_entry (pop_entry),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.enc       (enc)
	);

endmodule

`default_nettype wire

// ===== rtl/b64_front.sv =====
// Front end: collects bytes into 24-bit groups and pushes finished groups and the partial group that ends a message.
// Depends on b64_pkg and b64_byte_if.
`default_nettype none

module b64_front (
	input  wire logic           clk,
	input  wire logic           arst_n,
	b64_byte_if.sink            raw,
	output b64_pkg::b64_group_t push_entry,
	output logic                push_valid,
	input  wire logic           push_ready
);
	import b64_pkg::*;

	logic [15:0] pend_q;
	logic [1:0]  cnt_q;
	logic        accept;

	assign raw.ready  = push_ready;
	assign accept     = raw.valid && raw.ready;
	assign push_valid = raw.valid && ((cnt_q == 2'd2) || raw.end_of_message);

	always_comb begin
		push_entry.last = raw.end_of_message;
		case (cnt_q)
			2'd2: begin
				push_entry.group   = {pend_q, raw.data_byte};
				push_entry.present = 2'd3;
			end
			2'd1: begin
				push_entry.group   = {pend_q[15:8], raw.data_byte, 8'h00};
				push_entry.present = 2'd2;
			end
			default: begin
				push_entry.group   = {raw.data_byte, 16'h0000};
				push_entry.present = 2'd1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (accept) begin
			if (push_valid)
				cnt_q <= 2'd0;
			else
				cnt_q <= cnt_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && !push_valid) begin
			if (cnt_q == 2'd0)
				pend_q[15:8] <= raw.data_byte;
			else
				pend_q[7:0] <= raw.data_byte;
		end
	end

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3)
		else $error("pending count out of range");

endmodule

`default_nettype wire

// ===== rtl/b64_queue.sv =====
// Short group queue between front and back ends.
// Depends on b64_pkg.
`default_nettype none

module b64_queue #(
	parameter int DEPTH = 2
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire b64_pkg::b64_group_t push_entry,
	input  wire logic                push_valid,
	output logic                     push_ready,
	output b64_pkg::b64_group_t      pop_entry,
	output logic                     pop_valid,
	input  wire logic                pop_ready
);
	import b64_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	b64_group_t    mem_q [DEPTH];
	logic [PW-1:0] wr_q;
	logic [PW-1:0] rd_q;
	logic [CW-1:0] cnt_q;
	logic          push;
	logic          pop;

	assign push_ready = cnt_q != FULL_CNT;
	assign pop_valid  = cnt_q != '0;
	assign pop_entry  = mem_q[rd_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= (wr_q == LAST_PTR) ? '0 : wr_q + PW'(1);
			if (pop)
				rd_q <= (rd_q == LAST_PTR) ? '0 : rd_q + PW'(1);
			if (push && !pop)
				cnt_q <= cnt_q + CW'(1);
			else if (pop && !push)
				cnt_q <= cnt_q - CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= push_entry;
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= FULL_CNT)
		else $error("group queue overflow");

	a_cnt_track: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> (cnt_q == $past(cnt_q) + CW'(1)))
		else $error("group queue count lost a push");

endmodule

`default_nettype wire

// ===== rtl/b64_back.sv =====
// Back end: turns one queued group into four characters, one beat a cycle
// while the sink is ready, through a registered output. Depends on b64_pkg and b64_char_if.
`default_nettype none

module b64_back (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire b64_pkg::b64_group_t pop_entry,
	input  wire logic                pop_valid,
	output logic                     pop_ready,
	b64_char_if.source               enc
);
	import b64_pkg::*;

	b64_group_t        ent_q;
	logic              active_q;
	logic [1:0]        idx_q;
	logic              ovalid_q;
	logic [CHAR_W-1:0] ochar_q;
	logic              olast_q;
	logic              adv;
	logic [5:0]        sextet;
	logic [CHAR_W-1:0] next_char;

	assign adv       = active_q && (!ovalid_q || enc.ready);
	assign pop_ready = !active_q || (adv && (idx_q == 2'd3));

	always_comb begin
		case (idx_q)
			2'd0:    sextet = ent_q.group[23:18];
			2'd1:    sextet = ent_q.group[17:12];
			2'd2:    sextet = ent_q.group[11:6];
			default: sextet = ent_q.group[5:0];
		endcase
		if ((idx_q == 2'd2) && (ent_q.present < 2'd2))
			next_char = PAD_CHAR;
		else if ((idx_q == 2'd3) && (ent_q.present < 2'd3))
			next_char = PAD_CHAR;
		else
			next_char = sextet_char(sextet);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			idx_q    <= 2'd0;
			ovalid_q <= 1'b0;
		end else begin
			if (adv)
				idx_q <= idx_q + 2'd1;
			if (pop_ready)
				active_q <= pop_valid;
			if (adv)
				ovalid_q <= 1'b1;
			else if (enc.ready)
				ovalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop_ready && pop_valid)
			ent_q <= pop_entry;
		if (adv) begin
			ochar_q <= next_char;
			olast_q <= ent_q.last && (idx_q == 2'd3);
		end
	end

	assign enc.valid    = ovalid_q;
	assign enc.out_char = ochar_q;
	assign enc.out_last = olast_q;

	a_idx_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!active_q |-> (idx_q == 2'd0))
		else $error("character index not at start while idle");

	a_group_end: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && (idx_q == 2'd3)) |=> (idx_q == 2'd0))
		else $error("group did not end after fourth character");

endmodule

`default_nettype wire

// ===== bench/base64_encoder_tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for base64_encoder: directed table then random messages,
// every character compared against an in-bench encoder model, or the table's characters on typed rows.
// Depends on b64_pkg, b64_if and the encoder RTL.

module base64_encoder_tb;
	import b64_pkg::*;

	localparam int RESET_CYCLES   = 6;
	localparam int RANDOM_BYTES   = 136;
	localparam int DRAIN_CYCLES   = 16;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int PRINT_LIMIT    = 100;

	localparam logic [8*64-1:0] ALPHABET =
		"ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

	typedef struct packed {
		logic [BYTE_W-1:0] data;
		logic              eom;
		logic              typed;
		logic [31:0]       chars;
	} stim_row_t;

	typedef struct packed {
		logic [CHAR_W-1:0] ch;
		logic              last;
	} char_beat_t;

	localparam int DIRECTED_ROWS = 24;

	// chars holds the four ASCII characters of the group, used only where typed is set
	stim_row_t directed_rows [0:DIRECTED_ROWS-1] = '{
		'{8'h00, 1'b1, 1'b1, "AA=="},
		'{8'hFF, 1'b1, 1'b1, "/w=="},
		'{8'h00, 1'b0, 1'b0, 32'h0},
		'{8'h00, 1'b1, 1'b1, "AAA="},
		'{8'hFF, 1'b0, 1'b0, 32'h0},
		'{8'hFF, 1'b1, 1'b1, "//8="},
		'{8'h00, 1'b0, 1'b0, 32'h0},
		'{8'h00, 1'b0, 1'b0, 32'h0},
		'{8'h00, 1'b0, 1'b1, "AAAA"},
		'{8'hFF, 1'b0, 1'b0, 32'h0},
		'{8'hFF, 1'b0, 1'b0, 32'h0},
		'{8'hFF, 1'b1, 1'b1, "////"},
		'{8'h4D, 1'b1, 1'b1, "TQ=="},
		'{8'h4D, 1'b0, 1'b0, 32'h0},
		'{8'h61, 1'b1, 1'b1, "TWE="},
		'{8'h4D, 1'b0, 1'b0, 32'h0},
		'{8'h61, 1'b0, 1'b0, 32'h0},
		'{8'h6E, 1'b0, 1'b1, "TWFu"},
		'{8'hFB, 1'b0, 1'b0, 32'h0},
		'{8'hFF, 1'b0, 1'b0, 32'h0},
		'{8'hBF, 1'b0, 1'b0, 32'h0},
		'{8'h3E, 1'b1, 1'b0, 32'h0},
		'{8'h80, 1'b0, 1'b0, 32'h0},
		'{8'h01, 1'b1, 1'b0, 32'h0}
	};

	logic clk = 1'b0;
	logic arst_n;

	b64_byte_if raw_if ();
	b64_char_if enc_if ();

	base64_encoder dut (
		.clk    (clk),
		.arst_n (arst_n),
		.raw    (raw_if),
		.enc    (enc_if)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// encoder model state
	logic [15:0] held_bytes;
	logic [1:0]  held_count;
	char_beat_t  owed_chars [$];

	int  mismatch_count;
	int  chars_checked;
	int  bytes_sent;
	int  msgs_sent;
	int  idle_cycles;
	int  stall_left;
	bit  calm;
	char_beat_t got_beat;
	char_beat_t want_beat;

	function automatic logic [CHAR_W-1:0] b64_letter(input logic [5:0] idx);
		return ALPHABET[(63 - int'(idx)) * 8 +: CHAR_W];
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 55)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		else
			return $urandom_range(4, 20);
	endfunction

	task automatic encode_byte(input logic [BYTE_W-1:0] d, input logic eom,
			input logic typed, input logic [31:0] chars);
		logic [23:0]       grp;
		int                present;
		logic [CHAR_W-1:0] c [4];
		char_beat_t        beat;
		present = 0;
		grp = '0;
		if (held_count >= 2'd2) begin
			grp = {held_bytes, d};
			present = 3;
		end else if (!eom) begin
			if (held_count == 2'd0)
				held_bytes = {d, 8'h00};
			else
				held_bytes = {held_bytes[15:8], d};
			held_count = held_count + 2'd1;
		end else if (held_count == 2'd1) begin
			grp = {held_bytes[15:8], d, 8'h00};
			present = 2;
		end else begin
			grp = {d, 16'h0000};
			present = 1;
		end
		if (present != 0) begin
			c[0] = b64_letter(grp[23:18]);
			c[1] = b64_letter(grp[17:12]);
			c[2] = (present >= 2) ? b64_letter(grp[11:6]) : PAD_CHAR;
			c[3] = (present >= 3) ? b64_letter(grp[5:0]) : PAD_CHAR;
			if (typed) begin
				c[0] = chars[24 +: CHAR_W];
				c[1] = chars[16 +: CHAR_W];
				c[2] = chars[8 +: CHAR_W];
				c[3] = chars[0 +: CHAR_W];
			end
			for (int i = 0; i < 4; i++) begin
				beat.ch    = c[i];
				beat.last  = (i == 3) ? eom : 1'b0;
				owed_chars = {owed_chars, beat};
			end
			held_bytes = 16'h0000;
			held_count = 2'd0;
		end
	endtask

	// called at a rising edge; leaves valid high after the beat is taken
	task automatic send_byte(input logic [BYTE_W-1:0] d, input logic eom,
			input logic typed, input logic [31:0] chars);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			raw_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		raw_if.valid          <= 1'b1;
		raw_if.data_byte      <= d;
		raw_if.end_of_message <= eom;
		do
			@(posedge clk);
		while (!raw_if.ready);
		encode_byte(d, eom, typed, chars);
		bytes_sent++;
		if (eom)
			msgs_sent++;
	endtask

	// sink side stalls
	always @(posedge clk) begin
		if (!arst_n) begin
			enc_if.ready <= 1'b0;
			stall_left   <= 0;
		end else if (stall_left > 0) begin
			enc_if.ready <= 1'b0;
			stall_left   <= stall_left - 1;
		end else begin
			enc_if.ready <= 1'b1;
			if (!calm && $urandom_range(0, 99) < 30)
				stall_left <= ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3)
					: $urandom_range(4, 20);
		end
	end

	// character checker
	always @(posedge clk) begin
		if (arst_n && enc_if.valid && enc_if.ready) begin
			got_beat.ch   = enc_if.out_char;
			got_beat.last = enc_if.out_last;
			if (owed_chars.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= PRINT_LIMIT)
					$display("%0t: unexpected char beat: expected none, actual char %h last %b",
						$time, got_beat.ch, got_beat.last);
			end else begin
				want_beat = owed_chars.pop_front();
				chars_checked++;
				if (got_beat.ch !== want_beat.ch) begin
					mismatch_count++;
					if (mismatch_count <= PRINT_LIMIT)
						$display("%0t: out_char: expected %h, actual %h",
							$time, want_beat.ch, got_beat.ch);
				end
				if (got_beat.last !== want_beat.last) begin
					mismatch_count++;
					if (mismatch_count <= PRINT_LIMIT)
						$display("%0t: out_last: expected %b, actual %b",
							$time, want_beat.last, got_beat.last);
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((raw_if.valid && raw_if.ready) || (enc_if.valid && enc_if.ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t: watchdog: no beat for %0d cycles", $time, idle_cycles);
				$display("end of test: mismatches");
				$finish;
			end
		end
	end

	initial begin
		int               msg_len;
		int               random_sent;
		logic [BYTE_W-1:0] d;
		arst_n                = 1'b0;
		raw_if.valid          = 1'b0;
		raw_if.data_byte      = '0;
		raw_if.end_of_message = 1'b0;
		enc_if.ready          = 1'b0;
		held_bytes            = 16'h0000;
		held_count            = 2'd0;
		mismatch_count        = 0;
		chars_checked         = 0;
		bytes_sent            = 0;
		msgs_sent             = 0;
		idle_cycles           = 0;
		stall_left            = 0;
		calm                  = 1'b0;
		random_sent           = 0;

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < DIRECTED_ROWS; i++)
			send_byte(directed_rows[i].data, directed_rows[i].eom,
				directed_rows[i].typed, directed_rows[i].chars);

		while (random_sent < RANDOM_BYTES) begin
			msg_len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30)
				: $urandom_range(1, 7);
			if (msg_len > RANDOM_BYTES - random_sent)
				msg_len = RANDOM_BYTES - random_sent;
			calm = ($urandom_range(0, 4) == 0);
			for (int k = 0; k < msg_len; k++) begin
				case ($urandom_range(0, 19))
					0: d = 8'h00;
					1: d = 8'hFF;
					default: d = 8'($urandom_range(0, 255));
				endcase
				send_byte(d, (k == msg_len - 1), 1'b0, 32'h0);
				random_sent++;
			end
		end
		calm = 1'b0;
		raw_if.valid <= 1'b0;

		while (owed_chars.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Encoded %0d bytes in %0d messages; %0d characters checked.",
			bytes_sent, msgs_sent, chars_checked);
		$display("Directed extremes and padding cases, random messages with stalls on both sides.");
		if (mismatch_count == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
